FILE: sv/tckm_pkg.sv
package tckm_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 16;
    localparam int MAX_ITERS  = 64;
    localparam int ADDR_BITS  = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int SUM_BITS   = COORD_BITS + CNT_BITS;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int DIST_BITS  = SQ_BITS + 1;
    localparam int ITER_BITS  = 7;
    localparam int IDX_BITS   = 6;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_ITER_COUNT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_C1_X       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_C1_Y       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_C2_X       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_C2_Y       = 3'd4;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ITER_START,
        ST_SCAN,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic   start;
        coord_t s1x;
        coord_t s1y;
        coord_t s2x;
        coord_t s2y;
    } div_req_t;

    typedef struct packed {
        logic   done;
        coord_t q1x;
        coord_t q1y;
        coord_t q2x;
        coord_t q2y;
    } div_rsp_t;

    typedef struct packed {
        logic       valid;
        logic [IDX_BITS-1:0] iteration_index;
        coord_t     cent1_x;
        coord_t     cent1_y;
        coord_t     cent2_x;
        coord_t     cent2_y;
        logic [CNT_BITS-1:0] members_one;
        logic [CNT_BITS-1:0] members_two;
        logic       points_dropped;
        logic       final_result;
    } result_t;

endpackage

FILE: sv/tckm_if.sv
interface point_if (input logic clk);
    logic valid;
    logic ready;
    tckm_pkg::coord_t point_x;
    tckm_pkg::coord_t point_y;
    logic last_point;
    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface result_if (input logic clk);
    logic valid;
    logic ready;
    logic [tckm_pkg::IDX_BITS-1:0] iteration_index;
    tckm_pkg::coord_t cent1_x;
    tckm_pkg::coord_t cent1_y;
    tckm_pkg::coord_t cent2_x;
    tckm_pkg::coord_t cent2_y;
    logic [tckm_pkg::CNT_BITS-1:0] members_one;
    logic [tckm_pkg::CNT_BITS-1:0] members_two;
    logic points_dropped;
    logic final_result;
    modport source (output valid, iteration_index, cent1_x, cent1_y, cent2_x, cent2_y,
        members_one, members_two, points_dropped, final_result, input ready);
    modport sink (input valid, iteration_index, cent1_x, cent1_y, cent2_x, cent2_y,
        members_one, members_two, points_dropped, final_result, output ready);
endinterface

FILE: sv/tckm_ram.sv
module tckm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/tckm_div.sv
// Four signed quotients sum / count, truncating toward zero; a zero count passes the req value through.
// Restoring division, one quotient bit per cycle, four lanes in parallel.
module tckm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tckm_pkg::div_req_t            req,
    input  logic [tckm_pkg::SUM_BITS-1:0] s1x,
    input  logic [tckm_pkg::SUM_BITS-1:0] s1y,
    input  logic [tckm_pkg::SUM_BITS-1:0] s2x,
    input  logic [tckm_pkg::SUM_BITS-1:0] s2y,
    input  logic [tckm_pkg::CNT_BITS-1:0] n1,
    input  logic [tckm_pkg::CNT_BITS-1:0] n2,
    output tckm_pkg::div_rsp_t            rsp
);
    localparam int SB = tckm_pkg::SUM_BITS;
    localparam int CB = tckm_pkg::CNT_BITS;
    localparam int STEP_BITS = $clog2(SB + 1);

    logic [SB-1:0] quo_reg [4];
    logic [SB-1:0] quo_next [4];
    logic [CB:0]   rem_reg [4];
    logic [CB:0]   rem_next [4];
    logic [3:0]    neg_reg;
    logic [CB-1:0] n1_reg, n2_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [SB-1:0] mag [4];
    logic [SB-1:0] sgn_in [4];
    logic [SB-1:0] res [4];

    always_comb
    begin
        sgn_in[0] = s1x;
        sgn_in[1] = s1y;
        sgn_in[2] = s2x;
        sgn_in[3] = s2y;
        for (int k = 0; k < 4; k++)
        begin
            mag[k] = sgn_in[k][SB-1] ? (~sgn_in[k] + 1'b1) : sgn_in[k];
        end
        for (int k = 0; k < 4; k++)
        begin
            logic [CB:0] trial;
            logic [CB:0] dv;
            dv = (k < 2) ? {1'b0, n1_reg} : {1'b0, n2_reg};
            trial = {rem_reg[k][CB-1:0], quo_reg[k][SB-1]};
            if (trial >= dv)
            begin
                rem_next[k] = trial - dv;
                quo_next[k] = {quo_reg[k][SB-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial;
                quo_next[k] = {quo_reg[k][SB-2:0], 1'b0};
            end
            res[k] = neg_reg[k] ? (~quo_reg[k] + 1'b1) : quo_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_BITS'(SB - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            for (int k = 0; k < 4; k++)
            begin
                quo_reg[k] <= mag[k];
                rem_reg[k] <= '0;
                neg_reg[k] <= sgn_in[k][SB-1];
            end
            n1_reg <= n1;
            n2_reg <= n2;
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < 4; k++)
            begin
                quo_reg[k] <= quo_next[k];
                rem_reg[k] <= rem_next[k];
            end
        end
    end

    // Means of in-range points always fit the coordinate width.
    assign rsp.done = done_reg;
    assign rsp.q1x = (n1_reg != '0) ? res[0][tckm_pkg::COORD_BITS-1:0] : req.s1x;
    assign rsp.q1y = (n1_reg != '0) ? res[1][tckm_pkg::COORD_BITS-1:0] : req.s1y;
    assign rsp.q2x = (n2_reg != '0) ? res[2][tckm_pkg::COORD_BITS-1:0] : req.s2x;
    assign rsp.q2y = (n2_reg != '0) ? res[3][tckm_pkg::COORD_BITS-1:0] : req.s2y;
endmodule

FILE: sv/two_cluster_kmeans_2d.sv
// Channel   Dir  Payload
// pin       in   point_x, point_y, last_point
// rout      out  iteration_index, cent1_x..cent2_y, members_one/two, flags
// cfg       in   cfg_we, cfg_index, cfg_data
//
// Loading takes one point per cycle into the point RAMs; reset empties the set.
// Each iteration over N stored points: a setup state, a scan that reads the N points,
// the read/multiply/accumulate drain and divide start, a bit-serial divide and an emit state.
// Input is held off from the last point until the final result enters the output register.
// A result waits in its output register while rout.ready is low; the next emit waits.
module two_cluster_kmeans_2d (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [tckm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [tckm_pkg::CFG_DATA_BITS-1:0] cfg_data,
    point_if.sink   pin,
    result_if.source rout
);
    localparam int AB = tckm_pkg::ADDR_BITS;
    localparam int CB = tckm_pkg::CNT_BITS;
    localparam int SB = tckm_pkg::SUM_BITS;
    localparam int DB = tckm_pkg::DIFF_BITS;
    localparam int QB = tckm_pkg::SQ_BITS;
    localparam int WB = tckm_pkg::COORD_BITS;

    tckm_pkg::state_t state_reg, state_next;

    logic [tckm_pkg::ITER_BITS-1:0] iter_cfg_reg;
    tckm_pkg::coord_t st1x_reg, st1y_reg, st2x_reg, st2y_reg;
    tckm_pkg::coord_t c1x_reg, c1y_reg, c2x_reg, c2y_reg;
    logic [CB-1:0] loaded_reg;
    logic          ovf_reg;
    logic [tckm_pkg::ITER_BITS-1:0] iters_reg;
    logic [tckm_pkg::IDX_BITS-1:0]  iter_reg;
    logic [CB-1:0] rd_cnt_reg;
    logic          v1_reg, v2_reg;
    logic [QB-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg;
    tckm_pkg::coord_t px2_reg, py2_reg;
    logic [SB-1:0] s1x_reg, s1y_reg, s2x_reg, s2y_reg;
    logic [CB-1:0] n1_reg, n2_reg;
    tckm_pkg::result_t res_reg;
    logic          out_full_reg;

    logic in_fire, store_we, rd_en;
    tckm_pkg::coord_t rx, ry;
    tckm_pkg::div_req_t dreq;
    tckm_pkg::div_rsp_t drsp;
    logic [tckm_pkg::ITER_BITS-1:0] iters_clamped;
    logic [DB-1:0] a1x, a1y, a2x, a2y;
    logic [QB:0] dist1, dist2;
    logic closer1;

    assign pin.ready = (state_reg == tckm_pkg::ST_LOAD);
    assign in_fire = pin.valid && pin.ready;
    assign store_we = in_fire && (loaded_reg != CB'(tckm_pkg::MAX_POINTS));
    assign rd_en = (state_reg == tckm_pkg::ST_SCAN) && (rd_cnt_reg != loaded_reg);

    tckm_ram #(.WIDTH(WB), .DEPTH(tckm_pkg::MAX_POINTS)) u_ram_x (
        .clk(clk), .we(store_we), .waddr(loaded_reg[AB-1:0]), .wdata(pin.point_x),
        .raddr(rd_cnt_reg[AB-1:0]), .rdata(rx));
    tckm_ram #(.WIDTH(WB), .DEPTH(tckm_pkg::MAX_POINTS)) u_ram_y (
        .clk(clk), .we(store_we), .waddr(loaded_reg[AB-1:0]), .wdata(pin.point_y),
        .raddr(rd_cnt_reg[AB-1:0]), .rdata(ry));

    always_comb
    begin
        if (iter_cfg_reg == '0)
            iters_clamped = tckm_pkg::ITER_BITS'(1);
        else if (iter_cfg_reg > tckm_pkg::ITER_BITS'(tckm_pkg::MAX_ITERS))
            iters_clamped = tckm_pkg::ITER_BITS'(tckm_pkg::MAX_ITERS);
        else
            iters_clamped = iter_cfg_reg;
    end

    function automatic logic [DB-1:0] absd(tckm_pkg::coord_t a, tckm_pkg::coord_t b);
        logic signed [DB-1:0] d;
        d = DB'(a) - DB'(b);
        return d[DB-1] ? DB'(-d) : DB'(d);
    endfunction

    always_comb
    begin
        a1x = absd(rx, c1x_reg);
        a1y = absd(ry, c1y_reg);
        a2x = absd(rx, c2x_reg);
        a2y = absd(ry, c2y_reg);
        dist1 = {1'b0, d1x_reg} + {1'b0, d1y_reg};
        dist2 = {1'b0, d2x_reg} + {1'b0, d2y_reg};
        closer1 = dist1 < dist2;
    end

    assign dreq.start = (state_reg == tckm_pkg::ST_SCAN) && !rd_en && !v1_reg && !v2_reg;
    assign dreq.s1x = c1x_reg;
    assign dreq.s1y = c1y_reg;
    assign dreq.s2x = c2x_reg;
    assign dreq.s2y = c2y_reg;

    tckm_div u_div (
        .clk(clk), .rst_n(rst_n), .req(dreq),
        .s1x(s1x_reg), .s1y(s1y_reg), .s2x(s2x_reg), .s2y(s2y_reg),
        .n1(n1_reg), .n2(n2_reg), .rsp(drsp));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tckm_pkg::ST_LOAD:
                if (in_fire && pin.last_point) state_next = tckm_pkg::ST_ITER_START;
            tckm_pkg::ST_ITER_START:
                state_next = tckm_pkg::ST_SCAN;
            tckm_pkg::ST_SCAN:
                if (dreq.start) state_next = tckm_pkg::ST_DIVIDE;
            tckm_pkg::ST_DIVIDE:
                if (drsp.done) state_next = tckm_pkg::ST_EMIT;
            tckm_pkg::ST_EMIT:
                if (!out_full_reg || rout.ready)
                begin
                    if ({1'b0, iter_reg} + 1'b1 == iters_reg)
                        state_next = tckm_pkg::ST_LOAD;
                    else
                        state_next = tckm_pkg::ST_ITER_START;
                end
            default:
                state_next = tckm_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tckm_pkg::ST_LOAD;
            iter_cfg_reg <= tckm_pkg::ITER_BITS'(1);
            st1x_reg <= '0;
            st1y_reg <= '0;
            st2x_reg <= '0;
            st2y_reg <= '0;
            loaded_reg <= '0;
            ovf_reg <= 1'b0;
            iter_reg <= '0;
            iters_reg <= tckm_pkg::ITER_BITS'(1);
            rd_cnt_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tckm_pkg::REG_ITER_COUNT:
                        iter_cfg_reg <= cfg_data[tckm_pkg::ITER_BITS-1:0];
                    tckm_pkg::REG_C1_X: st1x_reg <= cfg_data;
                    tckm_pkg::REG_C1_Y: st1y_reg <= cfg_data;
                    tckm_pkg::REG_C2_X: st2x_reg <= cfg_data;
                    tckm_pkg::REG_C2_Y: st2y_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == tckm_pkg::ST_EMIT && (!out_full_reg || rout.ready))
                out_full_reg <= 1'b1;
            else if (rout.valid && rout.ready)
                out_full_reg <= 1'b0;
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            case (state_reg)
                tckm_pkg::ST_LOAD:
                    if (in_fire)
                    begin
                        if (store_we) loaded_reg <= loaded_reg + 1'b1;
                        else ovf_reg <= 1'b1;
                        if (pin.last_point)
                        begin
                            iters_reg <= iters_clamped;
                            iter_reg <= '0;
                        end
                    end
                tckm_pkg::ST_ITER_START:
                    rd_cnt_reg <= '0;
                tckm_pkg::ST_SCAN:
                    if (rd_en) rd_cnt_reg <= rd_cnt_reg + 1'b1;
                tckm_pkg::ST_EMIT:
                    if (!out_full_reg || rout.ready)
                    begin
                        iter_reg <= iter_reg + 1'b1;
                        if ({1'b0, iter_reg} + 1'b1 == iters_reg)
                        begin
                            loaded_reg <= '0;
                            ovf_reg <= 1'b0;
                        end
                    end
                default: ;
            endcase
        end
    end

    // Datapath: centroids, squared distances, sums.
    always_ff @(posedge clk)
    begin
        if (in_fire && pin.last_point && state_reg == tckm_pkg::ST_LOAD)
        begin
            c1x_reg <= st1x_reg;
            c1y_reg <= st1y_reg;
            c2x_reg <= st2x_reg;
            c2y_reg <= st2y_reg;
        end
        else if (state_reg == tckm_pkg::ST_DIVIDE && drsp.done)
        begin
            c1x_reg <= drsp.q1x;
            c1y_reg <= drsp.q1y;
            c2x_reg <= drsp.q2x;
            c2y_reg <= drsp.q2y;
        end
        if (state_reg == tckm_pkg::ST_ITER_START)
        begin
            s1x_reg <= '0;
            s1y_reg <= '0;
            s2x_reg <= '0;
            s2y_reg <= '0;
            n1_reg <= '0;
            n2_reg <= '0;
        end
        else if (v2_reg)
        begin
            if (closer1)
            begin
                s1x_reg <= s1x_reg + SB'(px2_reg);
                s1y_reg <= s1y_reg + SB'(py2_reg);
                n1_reg <= n1_reg + 1'b1;
            end
            else
            begin
                s2x_reg <= s2x_reg + SB'(px2_reg);
                s2y_reg <= s2y_reg + SB'(py2_reg);
                n2_reg <= n2_reg + 1'b1;
            end
        end
        if (v1_reg)
        begin
            d1x_reg <= a1x * a1x;
            d1y_reg <= a1y * a1y;
            d2x_reg <= a2x * a2x;
            d2y_reg <= a2y * a2y;
            px2_reg <= rx;
            py2_reg <= ry;
        end
        if (state_reg == tckm_pkg::ST_EMIT && (!out_full_reg || rout.ready))
        begin
            res_reg.valid <= 1'b1;
            res_reg.iteration_index <= iter_reg;
            res_reg.cent1_x <= c1x_reg;
            res_reg.cent1_y <= c1y_reg;
            res_reg.cent2_x <= c2x_reg;
            res_reg.cent2_y <= c2y_reg;
            res_reg.members_one <= n1_reg;
            res_reg.members_two <= n2_reg;
            res_reg.points_dropped <= ovf_reg;
            res_reg.final_result <= ({1'b0, iter_reg} + 1'b1 == iters_reg);
        end
    end

    assign rout.valid = out_full_reg;
    assign rout.iteration_index = res_reg.iteration_index;
    assign rout.cent1_x = res_reg.cent1_x;
    assign rout.cent1_y = res_reg.cent1_y;
    assign rout.cent2_x = res_reg.cent2_x;
    assign rout.cent2_y = res_reg.cent2_y;
    assign rout.members_one = res_reg.members_one;
    assign rout.members_two = res_reg.members_two;
    assign rout.points_dropped = res_reg.points_dropped;
    assign rout.final_result = res_reg.final_result;

`ifndef SYNTH
    a_no_input_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tckm_pkg::ST_LOAD) |-> !pin.ready)
        else $error("input taken during a run");
    a_members_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tckm_pkg::ST_DIVIDE) |-> (n1_reg + n2_reg == loaded_reg))
        else $error("member counts do not cover stored points");
    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= CB'(tckm_pkg::MAX_POINTS))
        else $error("point count beyond capacity");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rout.valid && !rout.ready) |=> rout.valid)
        else $error("result dropped while stalled");
`endif
endmodule
